### rtl/tmpg_pkg.sv
// ----------------------------------------------------------------------------
// tmpg_pkg: text-mode pixel generator shared definitions
// Grid geometry, memory depths, item kinds and stream field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package tmpg_pkg;

    localparam int TEXT_COLS   = 80;
    localparam int TEXT_ROWS   = 60;
    localparam int CELL_PIX    = 8;
    localparam int FRAME_W     = TEXT_COLS * CELL_PIX;
    localparam int FRAME_H     = TEXT_ROWS * CELL_PIX;
    localparam int CHAR_DEPTH  = TEXT_COLS * TEXT_ROWS;
    localparam int GLYPH_DEPTH = 1024;
    localparam int PAL_SIZE    = 8;

    localparam int ADDR_W  = 13;
    localparam int WORD_W  = 16;
    localparam int COLOR_W = 32;
    localparam int X_W     = 10;
    localparam int Y_W     = 9;
    localparam int CADDR_W = $clog2(CHAR_DEPTH);
    localparam int GADDR_W = $clog2(GLYPH_DEPTH);
    localparam int PIDX_W  = $clog2(PAL_SIZE);

    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 56;

    typedef enum logic [1:0] {
        KIND_CHAR_WR  = 2'd0,
        KIND_GLYPH_WR = 2'd1,
        KIND_TICK     = 2'd2,
        KIND_NONE     = 2'd3
    } kind_t;

    typedef logic [COLOR_W-1:0] color_t;

endpackage

`default_nettype wire

### rtl/text_mode_pixel_generator_unit.sv
// ----------------------------------------------------------------------------
// text_mode_pixel_generator_unit: 80x60 text-mode character generator
// Holds character and glyph memory, scans a 640x480 raster one pixel per tick.
// ----------------------------------------------------------------------------
// a pixel tick passes one registered stage each for character read, glyph read
// and palette select on its way to the output
// one item per cycle unless a stall fills the pipeline; memory writes take effect for the next item
// a stalled output fills the pipeline bubbles before s_axis_tready drops
// reset clears raster position, palette and pipeline valids; memory contents
// stay undefined until written
`default_nettype none

module text_mode_pixel_generator_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // address [12:0], data [28:13], zero pad [31:29]
    input  wire logic [tmpg_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // kind [1:0]
    input  wire logic [1:0]                      s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // pixel_color [31:0], pixel_x [41:32], pixel_y [50:42], zero pad [55:51]
    output logic [tmpg_pkg::M_DATA_W-1:0]        m_axis_tdata,
    // frame_end
    output logic                                 m_axis_tlast,
    input  wire logic                            cfg_we,
    input  wire logic [tmpg_pkg::PIDX_W-1:0]     cfg_index,
    input  wire logic [tmpg_pkg::COLOR_W-1:0]    cfg_data
);
    import tmpg_pkg::*;

    // memories
    logic [WORD_W-1:0] char_mem  [0:CHAR_DEPTH-1];
    logic [WORD_W-1:0] glyph_mem [0:GLYPH_DEPTH-1];

    color_t palette_reg [0:PAL_SIZE-1];

    // input unpacking
    logic [ADDR_W-1:0] in_addr;
    logic [WORD_W-1:0] in_data;
    kind_t             in_kind;

    assign in_addr = s_axis_tdata[ADDR_W-1:0];
    assign in_data = s_axis_tdata[ADDR_W+WORD_W-1:ADDR_W];
    assign in_kind = kind_t'(s_axis_tuser);

    // raster state
    logic [X_W-1:0]     x_reg, x_next;
    logic [Y_W-1:0]     y_reg, y_next;
    logic [CADDR_W-1:0] row_base_reg, row_base_next;
    logic [CADDR_W-1:0] caddr;
    logic               last_pix;

    // pipeline
    logic               v1_reg, v2_reg, v3_reg;
    logic               adv1, adv2, adv3;
    logic [X_W-1:0]     x1_reg, x2_reg;
    logic [Y_W-1:0]     y1_reg, y2_reg;
    logic               last1_reg, last2_reg;
    logic [WORD_W-1:0]  cword_reg;
    logic [WORD_W-1:0]  gword_reg;
    logic [PIDX_W-1:0]  fg2_reg, bg2_reg;
    logic [GADDR_W-1:0] gaddr;
    color_t             color_reg, color_next;
    logic [X_W-1:0]     x3_reg;
    logic [Y_W-1:0]     y3_reg;
    logic               last3_reg;
    logic [7:0]         gbits;

    logic accept, tick_acc, char_we, glyph_we;

    assign adv3 = !v3_reg || m_axis_tready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;

    assign s_axis_tready = adv1;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign tick_acc      = accept && (in_kind == KIND_TICK);
    assign char_we       = accept && (in_kind == KIND_CHAR_WR)
                           && (in_addr < ADDR_W'(CHAR_DEPTH));
    assign glyph_we      = accept && (in_kind == KIND_GLYPH_WR)
                           && (in_addr < ADDR_W'(GLYPH_DEPTH));

    // character address kept as a running row base plus the cell column
    assign caddr    = row_base_reg + CADDR_W'(x_reg[X_W-1:3]);
    assign last_pix = (x_reg >= X_W'(FRAME_W - 1)) && (y_reg >= Y_W'(FRAME_H - 1));

    always_comb
    begin
        x_next        = x_reg;
        y_next        = y_reg;
        row_base_next = row_base_reg;
        if (tick_acc)
        begin
            if (x_reg >= X_W'(FRAME_W - 1))
            begin
                x_next = '0;
                if (y_reg >= Y_W'(FRAME_H - 1))
                begin
                    y_next        = '0;
                    row_base_next = '0;
                end
                else
                begin
                    y_next = y_reg + 1'b1;
                    if (y_reg[2:0] == 3'b111)
                        row_base_next = row_base_reg + CADDR_W'(TEXT_COLS);
                end
            end
            else
            begin
                x_next = x_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg        <= '0;
            y_reg        <= '0;
            row_base_reg <= '0;
        end
        else
        begin
            x_reg        <= x_next;
            y_reg        <= y_next;
            row_base_reg <= row_base_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PAL_SIZE; i++)
                palette_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            palette_reg[cfg_index] <= cfg_data;
        end
    end

    // character memory: write and read on the accept edge
    always_ff @(posedge clk)
    begin
        if (char_we)
            char_mem[in_addr[CADDR_W-1:0]] <= in_data;
        if (adv1)
            cword_reg <= char_mem[caddr];
    end

    // glyph row r is byte r[0] of word glyph*4 + r/2
    assign gaddr = {cword_reg[7:0], y1_reg[2:1]};

    // read before write on the same edge keeps item order
    always_ff @(posedge clk)
    begin
        if (glyph_we)
            glyph_mem[in_addr[GADDR_W-1:0]] <= in_data;
        if (adv2)
            gword_reg <= glyph_mem[gaddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= tick_acc;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            x1_reg    <= x_reg;
            y1_reg    <= y_reg;
            last1_reg <= last_pix;
        end
        if (adv2)
        begin
            x2_reg    <= x1_reg;
            y2_reg    <= y1_reg;
            last2_reg <= last1_reg;
            fg2_reg   <= cword_reg[10:8];
            bg2_reg   <= cword_reg[14:12];
        end
        if (adv3)
        begin
            x3_reg    <= x2_reg;
            y3_reg    <= y2_reg;
            last3_reg <= last2_reg;
            color_reg <= color_next;
        end
    end

    assign gbits = y2_reg[0] ? gword_reg[15:8] : gword_reg[7:0];

    always_comb
    begin
        if (gbits[x2_reg[2:0]])
            color_next = palette_reg[fg2_reg];
        else
            color_next = palette_reg[bg2_reg];
    end

    assign m_axis_tvalid = v3_reg;
    assign m_axis_tlast  = last3_reg;
    assign m_axis_tdata  = {{(M_DATA_W-COLOR_W-X_W-Y_W){1'b0}}, y3_reg, x3_reg, color_reg};

    // assertions
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |->
            x3_reg == X_W'(FRAME_W - 1) && y3_reg == Y_W'(FRAME_H - 1))
        else $error("frame end flagged away from the last pixel");

    a_caddr_range: assert property (@(posedge clk) disable iff (!rst_n)
        tick_acc |-> caddr < CADDR_W'(CHAR_DEPTH))
        else $error("character address out of range");

    a_row_base: assert property (@(posedge clk) disable iff (!rst_n)
        row_base_reg == CADDR_W'(32'(y_reg[Y_W-1:3]) * TEXT_COLS))
        else $error("row base out of step with raster row");

    a_tick_enters: assert property (@(posedge clk) disable iff (!rst_n)
        tick_acc |=> v1_reg)
        else $error("accepted tick lost before first stage");

endmodule

`default_nettype wire

### tb/text_mode_pixel_generator_unit_test.sv
// ----------------------------------------------------------------------------
// text_mode_pixel_generator_unit_test: self-checking bench for the text-mode
// pixel generator
// Fills the character cells and glyph words that the raster reaches, runs
// directed edge items, then random write/tick traffic with random stalls on
// both streams and several palette settings. Every pixel item is checked
// against a local prediction of the raster, memories and palette.
// ----------------------------------------------------------------------------
module text_mode_pixel_generator_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import tmpg_pkg::*;

    localparam int MAX_GAP        = 13;
    localparam int LONG_HOLD      = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 400;
    // random cell words only pick glyphs below this, so only their words need filling
    localparam int GLYPHS_USED    = 16;
    localparam logic [WORD_W-1:0] CELL_MASK = {8'hFF, 8'(GLYPHS_USED - 1)};

    typedef enum int {
        PAL_ZERO,
        PAL_ONES,
        PAL_STRIPES,
        PAL_MIXED,
        PAL_RANDOM
    } palette_mode_t;

    typedef struct {
        kind_t                kind;
        logic [ADDR_W-1:0]    addr;
        logic [WORD_W-1:0]    data;
        int unsigned          gap;
    } stream_item_t;

    typedef struct {
        color_t               color;
        logic [X_W-1:0]       x;
        logic [Y_W-1:0]       y;
        logic                 last;
    } pixel_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    // address [12:0], data [28:13], zero pad [31:29]
    logic [S_DATA_W-1:0]      s_axis_tdata = '0;
    // kind [1:0]
    logic [1:0]               s_axis_tuser = KIND_NONE;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    // pixel_color [31:0], pixel_x [41:32], pixel_y [50:42], zero pad [55:51]
    logic [M_DATA_W-1:0]      m_axis_tdata;
    // frame_end
    logic                     m_axis_tlast;
    logic                     cfg_we = 1'b0;
    logic [PIDX_W-1:0]        cfg_index = '0;
    logic [COLOR_W-1:0]       cfg_data = '0;

    // local copy of the block state
    logic [WORD_W-1:0]        char_ram [0:CHAR_DEPTH-1];
    logic [WORD_W-1:0]        glyph_ram [0:GLYPH_DEPTH-1];
    color_t                   palette_regs [0:PAL_SIZE-1];
    logic [X_W-1:0]           ras_x = '0;
    logic [Y_W-1:0]           ras_y = '0;

    stream_item_t             item_queue [$];
    pixel_t                   expected_pixels [$];

    stream_item_t             next_item;
    stream_item_t             drv_item;
    logic                     drv_loaded = 1'b0;
    int unsigned              drv_wait = 0;
    int unsigned              cell_addr;
    logic [WORD_W-1:0]        cell_word;
    logic [WORD_W-1:0]        glyph_word;
    logic [7:0]               glyph_bits;
    pixel_t                   predicted;

    pixel_t                   oldest;
    int unsigned              rx_wait = 0;
    int unsigned              hold_requests = 0;
    int unsigned              hold_seen = 0;
    logic                     fast_mode = 1'b0;
    int unsigned              failures = 0;
    int unsigned              idle_cycles = 0;

    text_mode_pixel_generator_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // driver: applies each accepted item to the local state, then offers the next
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                case (drv_item.kind)
                    KIND_CHAR_WR:
                    begin
                        if (drv_item.addr < CHAR_DEPTH)
                            char_ram[drv_item.addr] = drv_item.data;
                    end
                    KIND_GLYPH_WR:
                    begin
                        if (drv_item.addr < GLYPH_DEPTH)
                            glyph_ram[drv_item.addr] = drv_item.data;
                    end
                    KIND_TICK:
                    begin
                        cell_addr = (ras_y >> 3) * TEXT_COLS + (ras_x >> 3);
                        cell_word = char_ram[cell_addr];
                        // glyph row r lives in byte r mod 2 of word glyph*4 + r/2
                        glyph_word = glyph_ram[{cell_word[7:0], ras_y[2:1]}];
                        glyph_bits = ras_y[0] ? glyph_word[15:8] : glyph_word[7:0];
                        predicted.color = glyph_bits[ras_x[2:0]] ?
                                          palette_regs[cell_word[10:8]] :
                                          palette_regs[cell_word[14:12]];
                        predicted.x = ras_x;
                        predicted.y = ras_y;
                        predicted.last = (ras_x == FRAME_W - 1) && (ras_y == FRAME_H - 1);
                        expected_pixels.push_back(predicted);
                        if (ras_x == FRAME_W - 1)
                        begin
                            ras_x = '0;
                            ras_y = (ras_y == FRAME_H - 1) ? '0 : ras_y + 1'b1;
                        end
                        else
                        begin
                            ras_x = ras_x + 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (!drv_loaded && item_queue.size() != 0)
                begin
                    next_item = item_queue.pop_front();
                    drv_wait = next_item.gap;
                    drv_loaded = 1'b1;
                end
                if (drv_loaded && drv_wait == 0)
                begin
                    drv_item = next_item;
                    drv_loaded = 1'b0;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {3'b000, next_item.data, next_item.addr};
                    s_axis_tuser <= next_item.kind;
                end
                else
                begin
                    if (drv_loaded)
                        drv_wait = drv_wait - 1;
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each pixel item against the oldest prediction, paces tready
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("pixel item with none expected: x=%0d y=%0d",
                           m_axis_tdata[41:32], m_axis_tdata[50:42]);
                    failures++;
                end
                else
                begin
                    oldest = expected_pixels.pop_front();
                    if (m_axis_tdata[31:0] !== oldest.color)
                    begin
                        $error("pixel_color expected %h actual %h",
                               oldest.color, m_axis_tdata[31:0]);
                        failures++;
                    end
                    if (m_axis_tdata[41:32] !== oldest.x)
                    begin
                        $error("pixel_x expected %0d actual %0d", oldest.x, m_axis_tdata[41:32]);
                        failures++;
                    end
                    if (m_axis_tdata[50:42] !== oldest.y)
                    begin
                        $error("pixel_y expected %0d actual %0d", oldest.y, m_axis_tdata[50:42]);
                        failures++;
                    end
                    if (m_axis_tlast !== oldest.last)
                    begin
                        $error("frame_end expected %0d actual %0d", oldest.last, m_axis_tlast);
                        failures++;
                    end
                end
            end
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                rx_wait = LONG_HOLD;
            end
            else if (m_axis_tvalid && m_axis_tready)
            begin
                rx_wait = fast_mode ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (rx_wait > 0)
            begin
                rx_wait = rx_wait - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // random colors and ignored bits, glyph index kept among the filled glyphs
    function automatic logic [WORD_W-1:0] random_cell_word();
        return WORD_W'($urandom) & CELL_MASK;
    endfunction

    task automatic queue_item(input kind_t kind, input logic [ADDR_W-1:0] addr,
                              input logic [WORD_W-1:0] data);
        stream_item_t it;
        it.kind = kind;
        it.addr = addr;
        it.data = data;
        it.gap = fast_mode ? 0 : $urandom_range(0, MAX_GAP);
        item_queue.push_back(it);
    endtask

    // mostly ticks and in-range writes, the rest ignored writes and unused kind
    task automatic queue_random_items(input int count);
        int unsigned pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                queue_item(KIND_TICK, ADDR_W'($urandom), WORD_W'($urandom));
            else if (pick < 65)
                // cells of the first two text rows; the raster is in the first during this part
                queue_item(KIND_CHAR_WR, ADDR_W'($urandom_range(0, 2 * TEXT_COLS - 1)),
                           random_cell_word());
            else if (pick < 75)
                queue_item(KIND_CHAR_WR, ADDR_W'($urandom_range(0, CHAR_DEPTH - 1)),
                           random_cell_word());
            else if (pick < 90)
                queue_item(KIND_GLYPH_WR, ADDR_W'($urandom_range(0, GLYPH_DEPTH - 1)),
                           WORD_W'($urandom));
            else if (pick < 93)
                queue_item(KIND_CHAR_WR, ADDR_W'($urandom_range(CHAR_DEPTH, 8191)),
                           WORD_W'($urandom));
            else if (pick < 96)
                queue_item(KIND_GLYPH_WR, ADDR_W'($urandom_range(GLYPH_DEPTH, 8191)),
                           WORD_W'($urandom));
            else
                queue_item(KIND_NONE, ADDR_W'($urandom), WORD_W'($urandom));
        end
    endtask

    // block drained: nothing queued, nothing offered, no pixel outstanding
    task automatic wait_idle();
        do
            @(negedge clk);
        while (item_queue.size() != 0 || drv_loaded || s_axis_tvalid ||
               expected_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_palette(input palette_mode_t mode);
        color_t c;
        for (int i = 0; i < PAL_SIZE; i++)
        begin
            case (mode)
                PAL_ZERO:    c = '0;
                PAL_ONES:    c = '1;
                PAL_STRIPES: c = i[0] ? 32'hAAAA_AAAA : 32'h5555_5555;
                PAL_MIXED:   c = (i == 0) ? '0 : (i == PAL_SIZE - 1) ? '1 : $urandom;
                default:     c = $urandom;
            endcase
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= i[PIDX_W-1:0];
            cfg_data <= c;
            palette_regs[i] = c;
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        for (int i = 0; i < PAL_SIZE; i++)
            palette_regs[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        program_palette(PAL_MIXED);

        // the raster stays in the first text row, so fill its cells and the
        // glyphs that cell words can name before anything is displayed
        for (int i = 0; i < TEXT_COLS; i++)
            queue_item(KIND_CHAR_WR, ADDR_W'(i), random_cell_word());
        for (int i = 0; i < 4 * GLYPHS_USED; i++)
            queue_item(KIND_GLYPH_WR, ADDR_W'(i), WORD_W'($urandom));
        for (int i = GLYPH_DEPTH - 4; i < GLYPH_DEPTH; i++)
            queue_item(KIND_GLYPH_WR, ADDR_W'(i), WORD_W'($urandom));
        wait_idle();

        // unused kind and out-of-range writes must leave memory alone
        queue_item(KIND_NONE, '1, '1);
        queue_item(KIND_CHAR_WR, ADDR_W'(CHAR_DEPTH), '1);
        queue_item(KIND_CHAR_WR, '1, '1);
        queue_item(KIND_GLYPH_WR, ADDR_W'(GLYPH_DEPTH), '1);
        queue_item(KIND_GLYPH_WR, '1, '1);
        // glyph 0 under bg 7 / fg 1 with both ignored bits set
        queue_item(KIND_GLYPH_WR, '0, 16'hA501);
        queue_item(KIND_CHAR_WR, '0, 16'hF900);
        // glyph 255 in fg 6 / bg 0 next to it
        queue_item(KIND_GLYPH_WR, ADDR_W'(1020), 16'h80C3);
        queue_item(KIND_CHAR_WR, ADDR_W'(1), 16'h06FF);
        // top character and glyph addresses still take writes
        queue_item(KIND_CHAR_WR, ADDR_W'(CHAR_DEPTH - 1), '1);
        queue_item(KIND_GLYPH_WR, ADDR_W'(GLYPH_DEPTH - 1), '1);
        for (int i = 0; i < 14; i++)
            queue_item(KIND_TICK, ADDR_W'($urandom), WORD_W'($urandom));
        wait_idle();

        program_palette(PAL_ZERO);
        queue_random_items(PHASE_ITEMS);
        wait_idle();

        program_palette(PAL_ONES);
        queue_random_items(PHASE_ITEMS);
        wait_idle();

        program_palette(PAL_RANDOM);
        fast_mode <= 1'b1;
        @(posedge clk);
        queue_random_items(PHASE_ITEMS);
        wait_idle();
        fast_mode <= 1'b0;
        @(posedge clk);

        // output held off for a long stretch while input keeps coming
        program_palette(PAL_STRIPES);
        queue_random_items(PHASE_ITEMS);
        repeat (40) @(posedge clk);
        hold_requests <= hold_requests + 1;
        wait_idle();

        repeat (4 * SETTLE_CYCLES) @(posedge clk);
        if (expected_pixels.size() != 0)
            $error("%0d pixel items never arrived", expected_pixels.size());
        if (failures == 0 && expected_pixels.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### sim.f
rtl/tmpg_pkg.sv
rtl/text_mode_pixel_generator_unit.sv
tb/text_mode_pixel_generator_unit_test.sv
